>>> rtl/xtea_pkg.sv
package xtea_pkg;

  localparam int unsigned WordWidth  = 32;
  localparam int unsigned RoundWidth = 7;
  localparam int unsigned IndexWidth = 3;

  localparam logic [WordWidth-1:0] Delta = 32'h9E37_79B9;
  localparam logic [RoundWidth-1:0] RoundReset = 7'd32;

  localparam logic [IndexWidth-1:0] CfgKeyZero    = 3'd0;
  localparam logic [IndexWidth-1:0] CfgKeyOne     = 3'd1;
  localparam logic [IndexWidth-1:0] CfgKeyTwo     = 3'd2;
  localparam logic [IndexWidth-1:0] CfgKeyThree   = 3'd3;
  localparam logic [IndexWidth-1:0] CfgRoundCount = 3'd4;

  typedef logic [3:0][WordWidth-1:0] key_t;

  typedef struct packed {
    logic load;
    logic step;
    logic store;
  } dp_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  function automatic logic [WordWidth-1:0] mix(input logic [WordWidth-1:0] x);
    return ((x << 4) ^ (x >> 5)) + x;
  endfunction

endpackage

>>> rtl/xtea_config.sv
module xtea_config #(
  parameter int unsigned MAX_ROUNDS = 64,
  parameter int unsigned CW = 7
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [xtea_pkg::IndexWidth-1:0]      cfg_index,
  input  logic [xtea_pkg::WordWidth-1:0]       cfg_data,
  output xtea_pkg::key_t                       keys,
  output logic [CW-1:0]                        rounds
);

  logic [xtea_pkg::RoundWidth-1:0] round_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      keys        <= '0;
      round_count <= xtea_pkg::RoundReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        xtea_pkg::CfgKeyZero:    keys[0] <= cfg_data;
        xtea_pkg::CfgKeyOne:     keys[1] <= cfg_data;
        xtea_pkg::CfgKeyTwo:     keys[2] <= cfg_data;
        xtea_pkg::CfgKeyThree:   keys[3] <= cfg_data;
        xtea_pkg::CfgRoundCount: round_count <= cfg_data[xtea_pkg::RoundWidth-1:0];
        default: ;
      endcase
    end
  end

  // Counts above the limit are saturated; the result always fits the counter.
  always_comb begin
    if ({2'b00, round_count} > 9'(MAX_ROUNDS)) begin
      rounds = CW'(MAX_ROUNDS);
    end else begin
      rounds = CW'(round_count);
    end
  end

endmodule

>>> rtl/xtea_datapath.sv
module xtea_datapath #(
  parameter int unsigned CW = 7
) (
  input  logic                             clk,
  input  xtea_pkg::dp_cmd_t                cmd,
  input  xtea_pkg::key_t                   keys,
  input  logic [CW-1:0]                    rounds,
  input  logic                             mode,
  input  logic [xtea_pkg::WordWidth-1:0]   first_word,
  input  logic [xtea_pkg::WordWidth-1:0]   second_word,
  output logic [xtea_pkg::WordWidth-1:0]   out_first_word,
  output logic [xtea_pkg::WordWidth-1:0]   out_second_word
);

  localparam int unsigned W = xtea_pkg::WordWidth;

  logic         decrypt;
  logic [W-1:0] v0;
  logic [W-1:0] v1;
  logic [W-1:0] sum;
  logic [W-1:0] v0_next;
  logic [W-1:0] v1_next;
  logic [W-1:0] sum_next;
  logic [W-1:0] sum_start;

  assign sum_start = W'(xtea_pkg::Delta * {{W{1'b0}}, rounds});

  // One full cipher cycle: the first half-round uses the current sum, the second the updated one.
  always_comb begin
    if (!decrypt) begin
      v0_next  = v0 + (xtea_pkg::mix(v1) ^ (sum + keys[sum[1:0]]));
      sum_next = sum + xtea_pkg::Delta;
      v1_next  = v1 + (xtea_pkg::mix(v0_next) ^ (sum_next + keys[sum_next[12:11]]));
    end else begin
      v1_next  = v1 - (xtea_pkg::mix(v0) ^ (sum + keys[sum[12:11]]));
      sum_next = sum - xtea_pkg::Delta;
      v0_next  = v0 - (xtea_pkg::mix(v1_next) ^ (sum_next + keys[sum_next[1:0]]));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      decrypt <= mode;
      v0      <= first_word;
      v1      <= second_word;
      sum     <= mode ? sum_start : '0;
    end else if (cmd.step) begin
      v0  <= v0_next;
      v1  <= v1_next;
      sum <= sum_next;
    end
    if (cmd.store) begin
      out_first_word  <= v0;
      out_second_word <= v1;
    end
  end

endmodule

>>> rtl/xtea_ctrl.sv
module xtea_ctrl #(
  parameter int unsigned CW = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [CW-1:0]     rounds,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output xtea_pkg::dp_cmd_t cmd
);

  xtea_pkg::state_t state;
  xtea_pkg::state_t state_next;
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  logic             out_free;

  assign in_ready = (state == xtea_pkg::ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    count_next = count;
    cmd        = '0;
    unique case (state)
      xtea_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          count_next = rounds;
          state_next = xtea_pkg::ST_RUN;
        end
      end
      xtea_pkg::ST_RUN: begin
        if (count != '0) begin
          cmd.step   = 1'b1;
          count_next = count - 1'b1;
        end else if (out_free) begin
          // The finished word moves to the output register once it is free.
          cmd.store  = 1'b1;
          state_next = xtea_pkg::ST_IDLE;
        end
      end
      default: state_next = xtea_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= xtea_pkg::ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (cmd.store) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/xtea_block_cipher.sv
// XTEA block cipher with one shared round unit that applies a full cipher cycle
// (both half-rounds) per clock. A word is taken when in_ready is high, which is
// whenever no block is in work; it is then loaded with the starting sum, passes
// through n cipher cycles in the round unit, where n is the configured round
// count saturated to MAX_ROUNDS, and moves into the output register once that
// register is free. The output register holds a finished word until it is
// taken, and the next word may be accepted meanwhile.
// Configuration writes (key words at indexes 0 to 3, round count at index 4)
// must only be made while the block is idle; other indexes are ignored.
module xtea_block_cipher #(
  parameter int unsigned MAX_ROUNDS = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [xtea_pkg::IndexWidth-1:0]     cfg_index,
  input  logic [xtea_pkg::WordWidth-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                mode,
  input  logic [xtea_pkg::WordWidth-1:0]      first_word,
  input  logic [xtea_pkg::WordWidth-1:0]      second_word,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [xtea_pkg::WordWidth-1:0]      out_first_word,
  output logic [xtea_pkg::WordWidth-1:0]      out_second_word
);

  localparam int unsigned CW = $clog2(MAX_ROUNDS + 1);

  xtea_pkg::key_t    keys;
  logic [CW-1:0]     rounds;
  xtea_pkg::dp_cmd_t cmd;

  xtea_config #(
    .MAX_ROUNDS(MAX_ROUNDS),
    .CW        (CW)
  ) u_config (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .keys     (keys),
    .rounds   (rounds)
  );

  xtea_ctrl #(
    .CW(CW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .rounds   (rounds),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd)
  );

  xtea_datapath #(
    .CW(CW)
  ) u_datapath (
    .clk            (clk),
    .cmd            (cmd),
    .keys           (keys),
    .rounds         (rounds),
    .mode           (mode),
    .first_word     (first_word),
    .second_word    (second_word),
    .out_first_word (out_first_word),
    .out_second_word(out_second_word)
  );

endmodule

>>> tb/xtea_cipher_checker.sv
module xtea_cipher_checker
  import xtea_pkg::*;
#(
  parameter int unsigned MaxRounds = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [IndexWidth-1:0] cfg_index,
  input  logic [WordWidth-1:0]  cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  mode,
  input  logic [WordWidth-1:0]  first_word,
  input  logic [WordWidth-1:0]  second_word,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [WordWidth-1:0]  out_first_word,
  input  logic [WordWidth-1:0]  out_second_word,
  output int unsigned           mismatch_count,
  output int unsigned           blocks_in_flight
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [WordWidth-1:0] word_t;

  typedef struct packed {
    word_t left;
    word_t right;
  } block_pair_t;

  key_t                  key_words;
  logic [RoundWidth-1:0] round_setting;
  block_pair_t           expected_blocks[$];

  function automatic word_t mix_word(input word_t x);
    return ((x << 4) ^ (x >> 5)) + x;
  endfunction

  // Applies the cipher under the key and round count held at this moment.
  function automatic block_pair_t cipher_block(input logic decrypt, input word_t left_in,
                                               input word_t right_in);
    word_t       left;
    word_t       right;
    word_t       sum;
    int unsigned cycles;
    block_pair_t result;
    left   = left_in;
    right  = right_in;
    cycles = (round_setting > MaxRounds) ? MaxRounds : round_setting;
    if (!decrypt) begin
      sum = '0;
      for (int unsigned i = 0; i < cycles; i++) begin
        left  += mix_word(right) ^ (sum + key_words[sum[1:0]]);
        sum   += Delta;
        right += mix_word(left) ^ (sum + key_words[sum[12:11]]);
      end
    end else begin
      // The starting sum wraps modulo 2^32, as the round sums do.
      sum = Delta * word_t'(cycles);
      for (int unsigned i = 0; i < cycles; i++) begin
        right -= mix_word(left) ^ (sum + key_words[sum[12:11]]);
        sum   -= Delta;
        left  -= mix_word(right) ^ (sum + key_words[sum[1:0]]);
      end
    end
    result.left  = left;
    result.right = right;
    return result;
  endfunction

  initial begin
    mismatch_count   = 0;
    blocks_in_flight = 0;
    key_words        = '0;
    round_setting    = RoundReset;
  end

  always @(posedge clk) begin
    block_pair_t oldest;
    if (rst) begin
      key_words     = '0;
      round_setting = RoundReset;
      expected_blocks.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CfgKeyZero:    key_words[0] = cfg_data;
          CfgKeyOne:     key_words[1] = cfg_data;
          CfgKeyTwo:     key_words[2] = cfg_data;
          CfgKeyThree:   key_words[3] = cfg_data;
          CfgRoundCount: round_setting = cfg_data[RoundWidth-1:0];
          default: ;
        endcase
      end
      // Results are checked before the word accepted at the same edge is
      // queued, so that no result can be matched against its own input.
      if (out_valid && out_ready) begin
        if (expected_blocks.size() == 0) begin
          $error("result word %h %h arrived with no word outstanding",
                 out_first_word, out_second_word);
          mismatch_count++;
        end else begin
          oldest = expected_blocks.pop_front();
          if (out_first_word !== oldest.left) begin
            $error("out_first_word: expected %h, got %h", oldest.left, out_first_word);
            mismatch_count++;
          end
          if (out_second_word !== oldest.right) begin
            $error("out_second_word: expected %h, got %h", oldest.right, out_second_word);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_blocks.push_back(cipher_block(mode, first_word, second_word));
      end
    end
    blocks_in_flight = expected_blocks.size();
  end

endmodule

>>> tb/tb_xtea_block_cipher.sv
module tb_xtea_block_cipher;

  timeunit 1ns;
  timeprecision 1ps;

  import xtea_pkg::*;

  typedef logic [WordWidth-1:0] word_t;

  localparam int unsigned MaxRounds     = 64;
  localparam int unsigned RandomPhases  = 12;
  localparam int unsigned WordsPerPhase = 52;
  localparam int unsigned HoldPhase     = 3;
  localparam int unsigned PausePhase    = 5;
  localparam int unsigned LongHold      = 300;
  localparam int unsigned WatchdogLimit = 4000;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [IndexWidth-1:0] cfg_index;
  word_t                 cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic                  mode;
  word_t                 first_word;
  word_t                 second_word;
  logic                  out_valid;
  logic                  out_ready;
  word_t                 out_first_word;
  word_t                 out_second_word;

  int unsigned mismatch_count;
  int unsigned blocks_in_flight;
  int unsigned idle_cycles = 0;
  logic        gaps_on = 1'b1;
  logic        stalls_on = 1'b1;
  logic        long_hold_go = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  xtea_block_cipher #(
    .MAX_ROUNDS(MaxRounds)
  ) dut (
    .clk,
    .rst,
    .cfg_we,
    .cfg_index,
    .cfg_data,
    .in_valid,
    .in_ready,
    .mode,
    .first_word,
    .second_word,
    .out_valid,
    .out_ready,
    .out_first_word,
    .out_second_word
  );

  xtea_cipher_checker #(
    .MaxRounds(MaxRounds)
  ) checker_inst (
    .clk,
    .rst,
    .cfg_we,
    .cfg_index,
    .cfg_data,
    .in_valid,
    .in_ready,
    .mode,
    .first_word,
    .second_word,
    .out_valid,
    .out_ready,
    .out_first_word,
    .out_second_word,
    .mismatch_count,
    .blocks_in_flight
  );

  // A run that accepts nothing for too long has hung.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : receiver
    int unsigned stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_go) begin
        long_hold_go = 1'b0;
        stall_left   = LongHold;
      end else if (stall_left == 0 && stalls_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 4);
      end
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic word_t random_word();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      2:       return word_t'(1) << $urandom_range(0, WordWidth - 1);
      default: return $urandom();
    endcase
  endfunction

  function automatic key_t random_key();
    key_t k;
    case ($urandom_range(0, 7))
      0:       k = '0;
      1:       k = '1;
      default: for (int i = 0; i < 4; i++) k[i] = random_word();
    endcase
    return k;
  endfunction

  // The upper data bits are noise; only the low bits hold the round count.
  function automatic word_t random_round_data();
    logic [RoundWidth-1:0] r;
    case ($urandom_range(0, 7))
      0:       r = '0;
      1:       r = RoundWidth'(1);
      2:       r = RoundWidth'(MaxRounds);
      3:       r = RoundWidth'($urandom_range(MaxRounds + 1, (1 << RoundWidth) - 1));
      default: r = RoundWidth'($urandom_range(2, 40));
    endcase
    return word_t'({$urandom(), r});
  endfunction

  // Called at a falling edge; returns at a falling edge with valid left high
  // unless a gap was taken.
  task automatic send_block(input logic m, input word_t a, input word_t b);
    in_valid    <= 1'b1;
    mode        <= m;
    first_word  <= a;
    second_word <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  // Holds the sender back until every word sent has come out, then lets the
  // core run on for a full block time before anything else is done.
  task automatic settle_block();
    in_valid <= 1'b0;
    @(negedge clk);
    while (blocks_in_flight != 0) @(negedge clk);
    repeat (MaxRounds + 4) @(negedge clk);
  endtask

  task automatic config_write(input logic [IndexWidth-1:0] index, input word_t data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_settings(input key_t k, input word_t round_data);
    settle_block();
    config_write(CfgKeyZero, k[0]);
    config_write(CfgKeyOne, k[1]);
    config_write(CfgKeyTwo, k[2]);
    config_write(CfgKeyThree, k[3]);
    config_write(CfgRoundCount, round_data);
  endtask

  initial begin : stimulus
    key_t vector_key;
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    mode        = 1'b0;
    first_word  = '0;
    second_word = '0;
    vector_key  = {32'h0C0D_0E0F, 32'h0809_0A0B, 32'h0405_0607, 32'h0001_0203};
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Settings straight out of reset: zero key and a round count of 32.
    send_block(1'b0, '0, '0);
    send_block(1'b1, '0, '0);

    load_settings(vector_key, word_t'(32));
    send_block(1'b0, 32'h4142_4344, 32'h4546_4748);
    send_block(1'b1, 32'h497D_F3D0, 32'h7261_2CB5);
    send_block(1'b0, '1, '1);
    send_block(1'b1, '1, '0);
    send_block(1'b0, 32'h5555_5555, 32'hAAAA_AAAA);

    // A zero round count passes the word through in either direction.
    load_settings('1, word_t'(0));
    send_block(1'b0, 32'h0123_4567, 32'h89AB_CDEF);
    send_block(1'b1, 32'hFEDC_BA98, 32'h7654_3210);

    load_settings(vector_key, word_t'(1));
    send_block(1'b0, 32'h8000_0000, 32'h0000_0001);
    send_block(1'b1, 32'h0000_0001, 32'h8000_0000);

    load_settings(random_key(), word_t'(MaxRounds));
    // Writes to indexes beyond the round count must leave everything alone.
    for (int i = int'(CfgRoundCount) + 1; i < (1 << IndexWidth); i++) begin
      config_write(IndexWidth'(i), $urandom());
    end
    send_block(1'b0, random_word(), random_word());
    send_block(1'b1, random_word(), random_word());

    // Round counts beyond the limit saturate, decryption's starting sum too.
    load_settings(vector_key, word_t'(MaxRounds + 1));
    send_block(1'b0, 32'h4142_4344, 32'h4546_4748);
    send_block(1'b1, 32'h4142_4344, 32'h4546_4748);
    load_settings(random_key(), '1);
    send_block(1'b0, random_word(), random_word());
    send_block(1'b1, random_word(), random_word());

    for (int p = 0; p < RandomPhases; p++) begin
      load_settings(random_key(), random_round_data());
      if (p == RandomPhases - 1) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end else begin
        gaps_on   = (p % 3 != 2);
        stalls_on = (p % 4 != 1);
      end
      if (p == HoldPhase) long_hold_go = 1'b1;
      for (int i = 0; i < WordsPerPhase; i++) begin
        if (p == PausePhase && i == WordsPerPhase / 2) settle_block();
        send_block(1'($urandom_range(0, 1)), random_word(), random_word());
      end
    end

    settle_block();
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/xtea_pkg.sv
rtl/xtea_config.sv
rtl/xtea_datapath.sv
rtl/xtea_ctrl.sv
rtl/xtea_block_cipher.sv
tb/xtea_cipher_checker.sv
tb/tb_xtea_block_cipher.sv
